// ===== src/tet_pkg.sv =====
// Shared types and constants for the token expiry table.
`timescale 1ns / 1ps
package tet_pkg;

   // Action codes as they arrive on the request channel
   localparam logic [1:0] ACT_GENERATE = 2'd0;
   localparam logic [1:0] ACT_RENEW    = 2'd1;
   localparam logic [1:0] ACT_COUNT    = 2'd2;

   // Status codes returned with every response
   localparam logic [1:0] STATUS_DONE          = 2'd0;
   localparam logic [1:0] STATUS_RENEW_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL    = 2'd2;

   // Field widths
   localparam int unsigned ID_W     = 32;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned EXPIRY_W = 33;
   localparam int unsigned TTL_W    = 16;
   localparam int unsigned LIVE_W   = 5;
   localparam logic [LIVE_W-1:0] LIVE_MAX = '1;
   localparam logic [TTL_W-1:0]  TTL_RESET = 16'd5;

   // Command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   // Decoded operation
   typedef enum logic [1:0] {
      OP_GENERATE = 2'd0,
      OP_RENEW    = 2'd1,
      OP_COUNT    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   // One decoded command, key travels separately (its width is a parameter)
   typedef struct packed {
      op_type              op;
      logic [TIME_W-1:0]   now;
      logic [EXPIRY_W-1:0] expiry;
   } cmd_type;

endpackage

// ===== src/tet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tet_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tet_front.sv =====
// Request front end: accepts beats, decodes the action, queues commands.
`timescale 1ns / 1ps
module tet_front
   import tet_pkg::*;
#(
   parameter int unsigned KEY_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [ID_W-1:0]     req_token_id,
   input  logic [TIME_W-1:0]   req_now,
   input  logic [TTL_W-1:0]    ttl,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output cmd_type             cmd,
   output logic [KEY_BITS-1:0] cmd_key
);

   cmd_type             cmd_q_ff [QUEUE_DEPTH];
   logic [KEY_BITS-1:0] key_q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   cmd_type new_cmd;
   logic    push;
   logic    pop;

   // Decode the action and form the new expiry
   always_comb begin
      new_cmd.now    = req_now;
      new_cmd.expiry = {1'b0, req_now} + EXPIRY_W'(ttl);
      unique case (req_action)
         ACT_GENERATE: new_cmd.op = OP_GENERATE;
         ACT_RENEW:    new_cmd.op = OP_RENEW;
         ACT_COUNT:    new_cmd.op = OP_COUNT;
         default:      new_cmd.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = cmd_q_ff[rd_ptr_ff];
   assign cmd_key   = key_q_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= new_cmd;
         key_q_ff[wr_ptr_ff] <= KEY_BITS'(req_token_id);
      end
   end

endmodule

// ===== src/tet_back.sv =====
// Table engine: scans all entries with one comparator, updates, responds.
`timescale 1ns / 1ps
module tet_back
   import tet_pkg::*;
#(
   parameter int unsigned DEPTH    = 16,
   parameter int unsigned KEY_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  cmd_type             cmd,
   input  logic [KEY_BITS-1:0] cmd_key,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LIVE_W-1:0]   rsp_live_count,
   output logic [1:0]          rsp_status
);

   localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned ENTRY_W = KEY_BITS + EXPIRY_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Current command
   cmd_type             cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;

   // Scan pointer and compare stage
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   // Scan results
   logic             found_ff, found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             match_live_ff, match_live_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [LIVE_W-1:0] live_cnt_ff, live_cnt_in;

   // Entry valid bits
   logic [DEPTH-1:0] valid_ff, valid_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LIVE_W-1:0] rsp_live_ff, rsp_live_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // RAM ports
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [KEY_BITS-1:0] rd_key;
   logic [EXPIRY_W-1:0] rd_expiry;

   logic ent_valid;
   logic ent_hit;
   logic ent_live;
   logic out_free;

   tet_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (DEPTH),
      .ADDR_W (IDX_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   assign rd_key    = rd_data[KEY_BITS-1:0];
   assign rd_expiry = rd_data[ENTRY_W-1:KEY_BITS];

   // One entry compared per cycle
   assign ent_valid = valid_ff[cmp_idx_ff];
   assign ent_hit   = ent_valid && (rd_key == key_ff);
   assign ent_live  = ent_valid && (rd_expiry > {1'b0, cmd_ff.now});

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == ST_IDLE);
   assign wr_data   = {cmd_ff.expiry, key_ff};

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = scan_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_live_in = match_live_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      live_cnt_in   = live_cnt_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_live_in   = rsp_live_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = match_idx_ff;

      // Fold in the entry read last cycle
      if (cmp_vld_ff) begin
         if (ent_hit && !found_ff) begin
            found_in      = 1'b1;
            match_idx_in  = cmp_idx_ff;
            match_live_in = ent_live;
         end
         if (!ent_live && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
         if (cmd_ff.op == OP_COUNT) begin
            if (ent_live) begin
               if (live_cnt_ff != LIVE_MAX) begin
                  live_cnt_in = live_cnt_ff + 1'b1;
               end
            end else begin
               valid_in[cmp_idx_ff] = 1'b0;
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in        = cmd;
               key_in        = cmd_key;
               scan_in       = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               match_live_in = 1'b0;
               live_cnt_in   = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            if (scan_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_live_in   = '0;
               rsp_status_in = STATUS_DONE;
               case (cmd_ff.op)
                  OP_GENERATE: begin
                     if (found_ff) begin
                        wr_en = 1'b1;
                        wr_addr = match_idx_ff;
                     end else if (free_found_ff) begin
                        wr_en = 1'b1;
                        wr_addr = free_idx_ff;
                     end else begin
                        rsp_status_in = STATUS_TABLE_FULL;
                     end
                     if (wr_en) begin
                        valid_in[wr_addr] = 1'b1;
                     end
                  end
                  OP_RENEW: begin
                     if (found_ff && match_live_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = match_idx_ff;
                     end else begin
                        rsp_status_in = STATUS_RENEW_IGNORED;
                     end
                  end
                  OP_COUNT: begin
                     rsp_live_in = live_cnt_ff;
                  end
                  default: begin
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_vld_ff    <= 1'b0;
         found_ff      <= 1'b0;
         match_live_ff <= 1'b0;
         free_found_ff <= 1'b0;
         live_cnt_ff   <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         found_ff      <= found_in;
         match_live_ff <= match_live_in;
         free_found_ff <= free_found_in;
         live_cnt_ff   <= live_cnt_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_ff       <= scan_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      cmp_idx_ff    <= cmp_idx_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_live_count = rsp_live_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== src/token_expiry_table_core.sv =====
// Token expiry table: top level with the ttl register, front end and engine.
//
// Usage:
//   Requests arrive as req_ beats: req_tuser carries the action (generate,
//   renew, count), req_tdata carries the token id and the current time.
//   Every request produces exactly one rsp_ beat with the live count in
//   rsp_tdata and a status code in rsp_tuser.
//   csr_we / csr_wdata write the 16-bit ttl register (reset value 5); write
//   it only while no request is outstanding.
// Operation:
//   The engine starts each request, does one entry RAM read per cycle
//   through a single comparator, drains the last read, then updates and
//   responds. A two-beat queue in front takes requests while the engine
//   works and drops req_tready once it is full.
// Reset:
//   Synchronous, active high; the table comes up empty (all entries free),
//   the queue and response register empty, ttl at 5. No clearing pass.
// Back pressure:
//   A response waits in its register while rsp_tready is low; the engine
//   holds its next update until it is taken, then the queue fills up.
`timescale 1ns / 1ps
module token_expiry_table_core
   import tet_pkg::*;
#(
   parameter int unsigned DEPTH    = 16,
   parameter int unsigned KEY_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   // Configuration
   input  logic             csr_we,
   input  logic [TTL_W-1:0] csr_wdata,
   // Request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [63:0]      req_tdata,   // [31:0] token_id, [63:32] now
   input  logic [1:0]       req_tuser,   // [1:0] action
   // Response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [4:0] live_count, [7:5] zero
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   logic [TTL_W-1:0]    ttl_ff;
   logic                cmd_valid;
   logic                cmd_ready;
   cmd_type             cmd;
   logic [KEY_BITS-1:0] cmd_key;
   logic [LIVE_W-1:0]   live_count;

   // ttl register
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TTL_RESET;
      end else if (csr_we) begin
         ttl_ff <= csr_wdata;
      end
   end

   tet_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_action   (req_tuser),
      .req_token_id (req_tdata[ID_W-1:0]),
      .req_now      (req_tdata[ID_W+TIME_W-1:ID_W]),
      .ttl          (ttl_ff),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .cmd_key      (cmd_key)
   );

   tet_back #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd),
      .cmd_key        (cmd_key),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_live_count (live_count),
      .rsp_status     (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, live_count};

endmodule

// ===== verif/token_expiry_table_core_tb.sv =====
// Self-checking testbench for the token expiry table core: directed rows, then random phases.
`timescale 1ns / 1ps
module token_expiry_table_core_tb;
   import tet_pkg::*;

   localparam int unsigned TABLE_DEPTH  = 16;
   localparam int unsigned LIMIT_CYCLES = 600000;
   localparam int unsigned TAIL_CYCLES  = 60;
   localparam int unsigned ID_POOL      = 24;
   localparam int unsigned PHASES       = 6;
   localparam int unsigned PHASE_ITEMS  = 265;

   // One response beat as the table reports it
   typedef struct packed {
      logic [LIVE_W-1:0] live;
      logic [1:0]        status;
   } token_reply_type;

   // One row of the directed table; typed answers only where obvious
   typedef struct {
      logic [1:0]        act;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] stamp;
      bit                known;
      token_reply_type   reply;
   } directed_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              csr_we     = 1'b0;
   logic [TTL_W-1:0]  csr_wdata  = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata  = '0;   // [31:0] token_id, [63:32] now
   logic [1:0]        req_tuser  = '0;   // [1:0] action
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;         // [4:0] live_count, [7:5] zero
   logic [1:0]        rsp_tuser;         // [1:0] status

   // Shadow copy of the table and the ttl register
   logic              ent_valid  [TABLE_DEPTH];
   logic [ID_W-1:0]   ent_key    [TABLE_DEPTH];
   logic [EXPIRY_W-1:0] ent_expiry [TABLE_DEPTH];
   logic [TTL_W-1:0]  model_ttl;

   token_reply_type   reply_fifo[$];
   directed_row_type  directed_rows[$];
   logic [ID_W-1:0]   id_pool[ID_POOL];

   bit                gaps_on   = 1'b1;
   bit                stalls_on = 1'b1;
   int                failures  = 0;
   int                replies_seen = 0;
   int                full_seen = 0;
   int                ignored_seen = 0;
   int                action_seen[4] = '{0, 0, 0, 0};
   int unsigned       cycle_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   token_expiry_table_core #(
      .DEPTH    (TABLE_DEPTH),
      .KEY_BITS (ID_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // An entry is live while its expiry is strictly later than the request time
   function automatic bit entry_live(int i, logic [TIME_W-1:0] stamp);
      return ent_valid[i] && (ent_expiry[i] > {1'b0, stamp});
   endfunction

   // Apply one request to the shadow table and return the response it earns
   function automatic token_reply_type table_apply(logic [1:0] act, logic [ID_W-1:0] id,
                                                   logic [TIME_W-1:0] stamp);
      token_reply_type     r;
      logic [EXPIRY_W-1:0] new_exp;
      int                  slot;
      int                  live;
      int                  i;
      r       = '0;
      slot    = -1;
      live    = 0;
      new_exp = {1'b0, stamp} + EXPIRY_W'(model_ttl);
      case (act)
         ACT_GENERATE: begin
            // present id wins, even if expired; else lowest free entry
            for (i = 0; i < TABLE_DEPTH; i++)
               if (slot < 0 && ent_valid[i] && ent_key[i] == id) slot = i;
            for (i = 0; i < TABLE_DEPTH; i++)
               if (slot < 0 && !entry_live(i, stamp)) slot = i;
            if (slot < 0) begin
               r.status = STATUS_TABLE_FULL;
            end else begin
               ent_valid[slot]  = 1'b1;
               ent_key[slot]    = id;
               ent_expiry[slot] = new_exp;
            end
         end
         ACT_RENEW: begin
            for (i = 0; i < TABLE_DEPTH; i++)
               if (slot < 0 && ent_valid[i] && ent_key[i] == id) slot = i;
            if (slot >= 0 && entry_live(slot, stamp)) ent_expiry[slot] = new_exp;
            else r.status = STATUS_RENEW_IGNORED;
         end
         ACT_COUNT: begin
            // count live entries and free the rest
            for (i = 0; i < TABLE_DEPTH; i++) begin
               if (entry_live(i, stamp)) live++;
               else ent_valid[i] = 1'b0;
            end
            if (live > LIVE_MAX) r.live = LIVE_MAX;
            else r.live = live[LIVE_W-1:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_row(logic [1:0] act, logic [ID_W-1:0] id,
                                   logic [TIME_W-1:0] stamp, bit known,
                                   logic [LIVE_W-1:0] live, logic [1:0] status);
      directed_row_type row;
      row.act          = act;
      row.id           = id;
      row.stamp        = stamp;
      row.known        = known;
      row.reply.live   = live;
      row.reply.status = status;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Drive one request beat; valid stays up after the handshake so that
   // back-to-back beats need no extra step. Caller drops it when done.
   task automatic issue_request(input logic [1:0] act, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] stamp, input bit known,
                                input token_reply_type typed);
      token_reply_type predicted;
      int              gap;
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {stamp, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = table_apply(act, id, stamp);
      reply_fifo.insert(reply_fifo.size(), known ? typed : predicted);
      action_seen[act]++;
   endtask

   // Wait until the table has answered everything, then load a new ttl
   task automatic load_ttl(input logic [TTL_W-1:0] value);
      req_tvalid <= 1'b0;
      while (reply_fifo.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      model_ttl = value;
   endtask

   // Response side: random stall bursts while stalls_on is set
   initial begin : rsp_pacing
      int hold;
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 19);
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compare each response beat with the oldest expectation
   always @(posedge clock) begin : reply_check
      token_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         if (rsp_tuser == STATUS_TABLE_FULL) full_seen++;
         if (rsp_tuser == STATUS_RENEW_IGNORED) ignored_seen++;
         if (reply_fifo.size() == 0) begin
            $display("%0t: stray response beat: expected none, got live %0d status %0d",
                     $time, rsp_tdata[LIVE_W-1:0], rsp_tuser);
            failures++;
         end else begin
            want = reply_fifo.pop_front();
            if (rsp_tdata[LIVE_W-1:0] !== want.live) begin
               $display("%0t: live_count mismatch: expected %0d, got %0d",
                        $time, want.live, rsp_tdata[LIVE_W-1:0]);
               failures++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want.status, rsp_tuser);
               failures++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d responses still pending", $time, reply_fifo.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [1:0]        act;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] clock_now;
      logic [TTL_W-1:0]  phase_ttl[PHASES];
      int                pick;
      int                p;
      int                n;

      model_ttl = TTL_RESET;
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;

      // Small id pool so that generates and renews keep hitting each other
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (n = 2; n < ID_POOL; n++) id_pool[n] = $urandom;

      // ttl settings per phase: one, longest, zero, short random, any, reset value
      phase_ttl[0] = 16'd1;
      phase_ttl[1] = 16'hFFFF;
      phase_ttl[2] = 16'd0;
      phase_ttl[3] = TTL_W'($urandom_range(2, 200));
      phase_ttl[4] = TTL_W'($urandom);
      phase_ttl[5] = TTL_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, ttl at its reset value of 5
      add_row(ACT_COUNT,    32'h0,         32'h0,         1, 5'd0, STATUS_DONE);
      add_row(ACT_RENEW,    32'h1234_5678, 32'h0,         1, 5'd0, STATUS_RENEW_IGNORED);
      add_row(ACT_GENERATE, 32'h0,         32'h0,         1, 5'd0, STATUS_DONE);
      // entry 0 has expired by the top of the time range, so this id takes it over
      add_row(ACT_GENERATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 5'd0, STATUS_DONE);
      add_row(ACT_COUNT,    32'h0,         32'h0,         1, 5'd1, STATUS_DONE);
      add_row(ACT_RENEW,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 5'd0, STATUS_DONE);
      add_row(OP_NONE,      32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 5'd0, STATUS_DONE);
      // id 0 lost its entry above, so the renew is ignored
      add_row(ACT_RENEW,    32'h0,         32'd5,         1, 5'd0, STATUS_RENEW_IGNORED);
      // id 0 goes back in at the lowest free entry, expiry 10
      add_row(ACT_GENERATE, 32'h0,         32'd5,         1, 5'd0, STATUS_DONE);
      // renew right at the expiry: already expired
      add_row(ACT_RENEW,    32'h0,         32'd10,        1, 5'd0, STATUS_RENEW_IGNORED);
      // generate on an expired but present id updates it in place
      add_row(ACT_GENERATE, 32'h0,         32'd10,        1, 5'd0, STATUS_DONE);
      // fill the rest of the table
      for (n = 1; n <= TABLE_DEPTH - 2; n++)
         add_row(ACT_GENERATE, 32'h1000_0000 + n, 32'd6, 0, 5'd0, STATUS_DONE);
      add_row(ACT_GENERATE, 32'hDEAD_BEEF, 32'd6,         1, 5'd0, STATUS_TABLE_FULL);
      add_row(ACT_COUNT,    32'h0,         32'd6,         1, 5'd16, STATUS_DONE);
      // most entries run out here and get freed
      add_row(ACT_COUNT,    32'h0,         32'd11,        0, 5'd0, STATUS_DONE);

      foreach (directed_rows[i])
         issue_request(directed_rows[i].act, directed_rows[i].id, directed_rows[i].stamp,
                       directed_rows[i].known, directed_rows[i].reply);

      // Random phases, one ttl each; the last one runs without idling
      for (p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         load_ttl(phase_ttl[p]);
         // the longest ttl starts near the top of the time range to cross the wrap
         if (p == 1) clock_now = 32'hFFFF_0000;
         else clock_now = $urandom;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) act = ACT_GENERATE;
            else if (pick < 75) act = ACT_RENEW;
            else if (pick < 95) act = ACT_COUNT;
            else act = OP_NONE;
            if ($urandom_range(0, 9) == 0) id = $urandom;
            else id = id_pool[$urandom_range(0, ID_POOL - 1)];
            // time mostly creeps forward against the ttl, sometimes jumps anywhere
            pick = $urandom_range(0, 99);
            if (pick < 4) clock_now = $urandom;
            else if (pick < 30) clock_now += $urandom_range(0, model_ttl / 2 + 1);
            else clock_now += $urandom_range(0, model_ttl / 16 + 1);
            issue_request(act, id, clock_now, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (reply_fifo.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d generate, %0d renew, %0d count and %0d unused-code beats",
               action_seen[ACT_GENERATE], action_seen[ACT_RENEW], action_seen[ACT_COUNT],
               action_seen[OP_NONE]);
      $display("over %0d ttl settings; %0d responses checked, %0d table-full drops, %0d %s",
               PHASES + 1, replies_seen, full_seen, ignored_seen, "ignored renews");
      $display("%0d errors", failures);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tet_pkg.sv
src/tet_ram.sv
src/tet_front.sv
src/tet_back.sv
src/token_expiry_table_core.sv
verif/token_expiry_table_core_tb.sv
